/* hdl/stvg_pkg.sv */
// shared widths, codes, constant tables and types of the sphere tile vertex generator
// no dependencies; every other file imports this package
package stvg_pkg;

   localparam int CNT_W      = 8;
   localparam int SLICE_W    = 9;
   localparam int STACK_W    = 8;
   localparam int NUM_W      = 10;
   localparam int DEN_W      = 9;
   localparam int FOUR_W     = NUM_W + 2;
   localparam int VAL_W      = 16;
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_STACK_COUNT      = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_SLICE_COUNT = CSR_ADDR_W'(1);
   localparam logic [CNT_W-1:0]      STACK_COUNT_RST      = CNT_W'(1);
   localparam logic [CNT_W-1:0]      HALF_SLICE_COUNT_RST = CNT_W'(3);

   localparam int DEF_MAX_STACKS      = 255;
   localparam int DEF_MAX_HALF_SLICES = 255;
   localparam int DEF_FRAC_BITS       = 15;

   // Q30 trig arithmetic
   localparam int Q_BITS  = 30;
   localparam int A_W     = 31;
   localparam int A2_W    = 32;
   localparam int T_W     = 31;
   localparam int X_W     = 32;
   localparam int RECIP_W = 32;
   localparam int TRIG_W  = 32;
   localparam logic [T_W-1:0] Q_ONE       = T_W'(1) << Q_BITS;
   localparam logic [A_W-1:0] HALF_PI_Q30 = 31'h6487ED51;

   // long divider r*HP/den, four quotient bits per stage
   localparam int DIV_BITS   = DEN_W + A_W;
   localparam int DIV_STEP   = 4;
   localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

   localparam int HORNER_TERMS = 6;
   localparam int HORNER_LAT   = 3 * HORNER_TERMS;
   localparam int ANGLE_LAT    = 2 + DIV_STAGES + 1 + HORNER_LAT + 2;

   localparam logic [7:0] SIN_DIV [HORNER_TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
   localparam logic [7:0] COS_DIV [HORNER_TERMS] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
   localparam logic [RECIP_W-1:0] SIN_RECIP [HORNER_TERMS] = '{
      32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd20),
      32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd72),
      32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd156)};
   localparam logic [RECIP_W-1:0] COS_RECIP [HORNER_TERMS] = '{
      32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 32) / 64'd12),
      32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd56),
      32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd132)};

   typedef enum logic [1:0] {
      CORNER_TL = 2'd0,
      CORNER_TR = 2'd1,
      CORNER_BL = 2'd2,
      CORNER_BR = 2'd3
   } corner_type;

   localparam int VTX_PER_TILE = 6;
   localparam int VTX_IDX_W    = 3;
   localparam logic [VTX_IDX_W-1:0] LAST_VTX = VTX_IDX_W'(VTX_PER_TILE - 1);
   localparam corner_type CORNER_SEQ [VTX_PER_TILE] = '{
      CORNER_TL, CORNER_BL, CORNER_BR, CORNER_TL, CORNER_BR, CORNER_TR};

   typedef struct packed {
      corner_type corner;
      logic       last_vertex;
      logic       index_error;
   } vtx_tag_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } angle_type;

   typedef struct packed {
      logic        valid;
      vtx_tag_type tag;
      angle_type   theta;
      angle_type   phi;
   } vtx_job_type;

   typedef struct packed {
      logic [A_W-1:0]  a;
      logic [A2_W-1:0] a2;
      logic [1:0]      quad;
   } horner_carry_type;

endpackage

/* hdl/stvg_req_if.sv */
// tile request channel: slice and stack index of one tile
// depends on stvg_pkg
interface stvg_req_if import stvg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SLICE_W-1:0] slice_index;
   logic [STACK_W-1:0] stack_index;

   modport source (output valid, output slice_index, output stack_index, input ready);
   modport sink (input valid, input slice_index, input stack_index, output ready);
endinterface

/* hdl/stvg_rsp_if.sv */
// vertex result channel: position, normal and tags of one vertex
// depends on stvg_pkg
interface stvg_rsp_if import stvg_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] pos_x;
   logic signed [VAL_W-1:0] pos_y;
   logic signed [VAL_W-1:0] pos_z;
   logic signed [VAL_W-1:0] norm_x;
   logic signed [VAL_W-1:0] norm_y;
   logic signed [VAL_W-1:0] norm_z;
   logic [1:0]              corner;
   logic                    last_vertex;
   logic                    index_error;

   modport source (output valid, output pos_x, output pos_y, output pos_z, output norm_x,
                   output norm_y, output norm_z, output corner, output last_vertex,
                   output index_error, input ready);
   modport sink (input valid, input pos_x, input pos_y, input pos_z, input norm_x,
                 input norm_y, input norm_z, input corner, input last_vertex,
                 input index_error, output ready);
endinterface

/* hdl/stvg_csr_if.sv */
// register write channel: register index and write data
// depends on stvg_pkg
interface stvg_csr_if import stvg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] reg_index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

/* hdl/stvg_seq.sv */
// tile sequencer: holds one request and issues its six vertex jobs, one per cycle while en is high
// depends on stvg_pkg and stvg_req_if
module stvg_seq import stvg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [CNT_W-1:0]  stack_cnt,
   input  logic [CNT_W-1:0]  half_cnt,
   stvg_req_if.sink          req_chan,
   output vtx_job_type       job
);

   logic                 busy_ff, busy_in;
   logic [VTX_IDX_W-1:0] vtx_ff, vtx_in;
   logic [SLICE_W-1:0]   slice_ff;
   logic [STACK_W-1:0]   stack_ff;
   logic                 err_ff;
   logic [DEN_W-1:0]     den_theta_ff;
   logic [DEN_W-1:0]     den_phi_ff;
   logic                 take;
   corner_type           corner;

   assign req_chan.ready = en & (~busy_ff | (vtx_ff == LAST_VTX));
   assign take = req_chan.valid & req_chan.ready;

   always_comb begin
      busy_in = busy_ff;
      vtx_in = vtx_ff;
      if (en && busy_ff) begin
         if (vtx_ff == LAST_VTX) begin
            busy_in = 1'b0;
         end else begin
            vtx_in = vtx_ff + VTX_IDX_W'(1);
         end
      end
      if (take) begin
         busy_in = 1'b1;
         vtx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vtx_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         vtx_ff <= vtx_in;
      end
   end

   // a zero count makes every index out of range
   always_ff @(posedge clock) begin
      if (take) begin
         slice_ff <= req_chan.slice_index;
         stack_ff <= req_chan.stack_index;
         err_ff <= (req_chan.stack_index >= stack_cnt) |
                   (req_chan.slice_index >= {half_cnt, 1'b0});
         den_theta_ff <= {half_cnt, 1'b0};
         den_phi_ff <= {stack_cnt, 1'b0};
      end
   end

   assign corner = CORNER_SEQ[vtx_ff];

   always_comb begin
      job.valid = busy_ff;
      job.tag.corner = corner;
      job.tag.last_vertex = (vtx_ff == LAST_VTX);
      job.tag.index_error = err_ff;
      job.theta.num = NUM_W'(slice_ff) + NUM_W'(corner[0]);
      job.theta.den = den_theta_ff;
      job.phi.num = NUM_W'(stack_ff) + NUM_W'(corner[1]);
      job.phi.den = den_phi_ff;
   end

endmodule

/* hdl/stvg_horner.sv */
// pipelined sine and cosine series in Q30, three stages per term
// depends on stvg_pkg
module stvg_horner import stvg_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  horner_carry_type carry_i,
   output logic [T_W-1:0]   t_sin,
   output logic [T_W-1:0]   t_cos,
   output horner_carry_type carry_o
);

   logic [T_W-1:0]   ts_ff [HORNER_TERMS+1];
   logic [T_W-1:0]   tc_ff [HORNER_TERMS+1];
   horner_carry_type cy_ff [HORNER_TERMS+1];

   assign ts_ff[0] = Q_ONE;
   assign tc_ff[0] = Q_ONE;
   assign cy_ff[0] = carry_i;

   for (genvar j = 0; j < HORNER_TERMS; j++) begin : g_term
      // innermost divisor first
      localparam int DI = HORNER_TERMS - 1 - j;
      logic [X_W-1:0]        xs_a_ff, xc_a_ff;
      horner_carry_type      cy_a_ff;
      logic [X_W-1:0]        xs_b_ff, xc_b_ff;
      logic [RECIP_W-1:0]    qs_b_ff, qc_b_ff;
      horner_carry_type      cy_b_ff;
      logic [A2_W+T_W-1:0]   ps, pc;
      logic [X_W+RECIP_W-1:0] rs, rc;
      logic [X_W-1:0]        ds, dc, ss, sc;

      assign ps = (A2_W+T_W)'(cy_ff[j].a2) * (A2_W+T_W)'(ts_ff[j]);
      assign pc = (A2_W+T_W)'(cy_ff[j].a2) * (A2_W+T_W)'(tc_ff[j]);

      always_ff @(posedge clock) begin
         if (en) begin
            xs_a_ff <= X_W'(ps >> Q_BITS);
            xc_a_ff <= X_W'(pc >> Q_BITS);
            cy_a_ff <= cy_ff[j];
         end
      end

      // quotient estimate by reciprocal, low by at most one
      assign rs = (X_W+RECIP_W)'(xs_a_ff) * (X_W+RECIP_W)'(SIN_RECIP[DI]);
      assign rc = (X_W+RECIP_W)'(xc_a_ff) * (X_W+RECIP_W)'(COS_RECIP[DI]);

      always_ff @(posedge clock) begin
         if (en) begin
            xs_b_ff <= xs_a_ff;
            xc_b_ff <= xc_a_ff;
            qs_b_ff <= rs[X_W+RECIP_W-1:X_W];
            qc_b_ff <= rc[X_W+RECIP_W-1:X_W];
            cy_b_ff <= cy_a_ff;
         end
      end

      always_comb begin
         ds = xs_b_ff - qs_b_ff * X_W'(SIN_DIV[DI]);
         dc = xc_b_ff - qc_b_ff * X_W'(COS_DIV[DI]);
         ss = qs_b_ff + X_W'(ds >= X_W'(SIN_DIV[DI]));
         sc = qc_b_ff + X_W'(dc >= X_W'(COS_DIV[DI]));
         if (ss > X_W'(Q_ONE)) ss = X_W'(Q_ONE);
         if (sc > X_W'(Q_ONE)) sc = X_W'(Q_ONE);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ts_ff[j+1] <= Q_ONE - T_W'(ss);
            tc_ff[j+1] <= Q_ONE - T_W'(sc);
            cy_ff[j+1] <= cy_b_ff;
         end
      end
   end

   assign t_sin = ts_ff[HORNER_TERMS];
   assign t_cos = tc_ff[HORNER_TERMS];
   assign carry_o = cy_ff[HORNER_TERMS];

endmodule

/* hdl/stvg_angle.sv */
// sine and cosine of num/den of a full turn: quadrant split, long divider,
// series evaluation and quadrant fold; depends on stvg_pkg and stvg_horner
module stvg_angle import stvg_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  angle_type                ang,
   output logic signed [TRIG_W-1:0] sin_val,
   output logic signed [TRIG_W-1:0] cos_val
);

   logic [FOUR_W-1:0]   four;
   logic [2:0]          quo;
   logic [FOUR_W-1:0]   rem_full;
   logic [1:0]          quad_s1_ff, quad_s2_ff;
   logic [DEN_W-1:0]    rem_s1_ff, den_s1_ff, den_s2_ff;
   logic [DIV_BITS-1:0] dvd_s2_ff;

   logic [DEN_W-1:0]    drem_ff [DIV_STAGES+1];
   logic [DIV_BITS-1:0] ddq_ff [DIV_STAGES+1];
   logic [DEN_W-1:0]    dden_ff [DIV_STAGES+1];
   logic [1:0]          dquad_ff [DIV_STAGES+1];

   logic [2*A_W-1:0]    sq;
   horner_carry_type    hc_ff, hc_out;
   logic [T_W-1:0]      t_sin, t_cos;
   logic [2*A_W-1:0]    sp;
   logic [X_W-1:0]      s_raw_ff;
   logic [T_W-1:0]      c_f1_ff;
   logic [1:0]          quad_f1_ff;
   logic [T_W-1:0]      s_sat;
   logic signed [TRIG_W-1:0] sv, cv;

   // 4*num = q*den + r, q at most four for in-range indices
   assign four = {ang.num, 2'b00};
   always_comb begin
      if (four >= FOUR_W'(4) * FOUR_W'(ang.den)) begin
         quo = 3'd4;
      end else if (four >= FOUR_W'(3) * FOUR_W'(ang.den)) begin
         quo = 3'd3;
      end else if (four >= FOUR_W'(2) * FOUR_W'(ang.den)) begin
         quo = 3'd2;
      end else if (four >= FOUR_W'(ang.den)) begin
         quo = 3'd1;
      end else begin
         quo = 3'd0;
      end
      rem_full = four - FOUR_W'(quo) * FOUR_W'(ang.den);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quad_s1_ff <= quo[1:0];
         rem_s1_ff <= rem_full[DEN_W-1:0];
         den_s1_ff <= ang.den;
         quad_s2_ff <= quad_s1_ff;
         den_s2_ff <= den_s1_ff;
         dvd_s2_ff <= DIV_BITS'(rem_s1_ff) * DIV_BITS'(HALF_PI_Q30);
      end
   end

   assign drem_ff[0] = '0;
   assign ddq_ff[0] = dvd_s2_ff;
   assign dden_ff[0] = den_s2_ff;
   assign dquad_ff[0] = quad_s2_ff;

   // restoring division, quotient shifts in where the dividend shifts out
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      logic [DEN_W-1:0]    r;
      logic [DIV_BITS-1:0] d;
      logic [DEN_W:0]      t;

      always_comb begin
         r = drem_ff[s];
         d = ddq_ff[s];
         t = '0;
         for (int k = 0; k < DIV_STEP; k++) begin
            t = {r, d[DIV_BITS-1]};
            d = d << 1;
            if (t >= (DEN_W+1)'(dden_ff[s])) begin
               r = DEN_W'(t - (DEN_W+1)'(dden_ff[s]));
               d[0] = 1'b1;
            end else begin
               r = t[DEN_W-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            drem_ff[s+1] <= r;
            ddq_ff[s+1] <= d;
            dden_ff[s+1] <= dden_ff[s];
            dquad_ff[s+1] <= dquad_ff[s];
         end
      end
   end

   assign sq = (2*A_W)'(ddq_ff[DIV_STAGES][A_W-1:0]) * (2*A_W)'(ddq_ff[DIV_STAGES][A_W-1:0]);

   always_ff @(posedge clock) begin
      if (en) begin
         hc_ff.a <= ddq_ff[DIV_STAGES][A_W-1:0];
         hc_ff.a2 <= A2_W'(sq >> Q_BITS);
         hc_ff.quad <= dquad_ff[DIV_STAGES];
      end
   end

   stvg_horner u_horner (
      .clock   (clock),
      .en      (en),
      .carry_i (hc_ff),
      .t_sin   (t_sin),
      .t_cos   (t_cos),
      .carry_o (hc_out)
   );

   assign sp = (2*A_W)'(hc_out.a) * (2*A_W)'(t_sin);

   always_ff @(posedge clock) begin
      if (en) begin
         s_raw_ff <= X_W'(sp >> Q_BITS);
         c_f1_ff <= t_cos;
         quad_f1_ff <= hc_out.quad;
      end
   end

   always_comb begin
      s_sat = (s_raw_ff > X_W'(Q_ONE)) ? Q_ONE : T_W'(s_raw_ff);
      sv = TRIG_W'(s_sat);
      cv = TRIG_W'(c_f1_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         unique case (quad_f1_ff)
            2'd0: begin
               sin_val <= sv;
               cos_val <= cv;
            end
            2'd1: begin
               sin_val <= cv;
               cos_val <= -sv;
            end
            2'd2: begin
               sin_val <= -sv;
               cos_val <= -cv;
            end
            default: begin
               sin_val <= -cv;
               cos_val <= sv;
            end
         endcase
      end
   end

endmodule

/* hdl/sphere_tile_vertex_generator.sv */
// channel   | dir | carries                                        | accepted when
// req_chan  | in  | slice_index, stack_index of one tile           | valid & ready
// rsp_chan  | out | one vertex: pos, norm, corner, last, error     | valid & ready
// csr_chan  | in  | reg_index, wdata (stack_count, half_slice_cnt) | valid & ready
//
// each request yields six vertices; a request is taken when the sequencer is idle or as
// the last job of the one before issues; one vertex leaves per cycle unless the result
// port stalls, the sequencer issuing one vertex job a cycle sets that rate
// reset clears the sequencer, the valid bits and the registers to their defaults
// a stalled result port freezes the whole pipeline; csr writes are always taken
// depends on stvg_pkg, the three channel interfaces, stvg_seq and stvg_angle
module sphere_tile_vertex_generator import stvg_pkg::*; #(
   parameter int MAX_STACKS      = DEF_MAX_STACKS,
   parameter int MAX_HALF_SLICES = DEF_MAX_HALF_SLICES,
   parameter int FRAC_BITS       = DEF_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   stvg_req_if.sink    req_chan,
   stvg_rsp_if.source  rsp_chan,
   stvg_csr_if.sink    csr_chan
);

   localparam logic signed [63:0] NORM_HI = (64'sd1 <<< FRAC_BITS) - 64'sd1;
   localparam logic signed [63:0] NORM_LO = -(64'sd1 <<< FRAC_BITS);
   localparam logic signed [63:0] OUT_HI  = 64'sd32767;
   localparam logic signed [63:0] OUT_LO  = -64'sd32768;

   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int sh);
      logic [63:0] m;
      logic        neg;
      neg = v[63];
      m = neg ? 64'(-v) : 64'(v);
      if (sh > 0) begin
         m = (m + (64'd1 << (sh - 1))) >> sh;
      end
      return neg ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
                                                input logic signed [63:0] lo,
                                                input logic signed [63:0] hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   logic [CNT_W-1:0] stack_count_ff, half_slice_count_ff;
   logic [CNT_W-1:0] stack_eff, half_eff;
   logic             en;
   vtx_job_type      job;

   logic signed [TRIG_W-1:0] sin_t, cos_t, sin_p, cos_p;

   logic        vld_ff [ANGLE_LAT+2];
   vtx_tag_type tag_ff [ANGLE_LAT+2];

   logic signed [2*TRIG_W-1:0] xm_ff, ym_ff;
   logic signed [TRIG_W-1:0]   z1_ff, x2_ff, y2_ff, z2_ff;

   logic                    rsp_valid_ff;
   logic signed [VAL_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [VAL_W-1:0] norm_x_ff, norm_y_ff, norm_z_ff;
   vtx_tag_type             rsp_tag_ff;

   logic signed [VAL_W-1:0] pos_x_in, pos_y_in, pos_z_in;
   logic signed [VAL_W-1:0] norm_x_in, norm_y_in, norm_z_in;

   // register file
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff <= STACK_COUNT_RST;
         half_slice_count_ff <= HALF_SLICE_COUNT_RST;
      end else if (csr_chan.valid) begin
         if (csr_chan.reg_index == CSR_STACK_COUNT) begin
            stack_count_ff <= csr_chan.wdata;
         end else if (csr_chan.reg_index == CSR_HALF_SLICE_COUNT) begin
            half_slice_count_ff <= csr_chan.wdata;
         end
      end
   end

   assign stack_eff = (32'(stack_count_ff) < MAX_STACKS) ? stack_count_ff
                                                         : CNT_W'(MAX_STACKS);
   assign half_eff = (32'(half_slice_count_ff) < MAX_HALF_SLICES) ? half_slice_count_ff
                                                                  : CNT_W'(MAX_HALF_SLICES);

   // the whole pipeline moves only when the output register can take an item
   assign en = ~rsp_valid_ff | rsp_chan.ready;

   stvg_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .stack_cnt (stack_eff),
      .half_cnt  (half_eff),
      .req_chan  (req_chan),
      .job       (job)
   );

   stvg_angle u_theta (
      .clock   (clock),
      .en      (en),
      .ang     (job.theta),
      .sin_val (sin_t),
      .cos_val (cos_t)
   );

   stvg_angle u_phi (
      .clock   (clock),
      .en      (en),
      .ang     (job.phi),
      .sin_val (sin_p),
      .cos_val (cos_p)
   );

   // vertex tags ride alongside the trig pipelines
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ANGLE_LAT + 2; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= job.valid;
         for (int i = 1; i < ANGLE_LAT + 2; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= job.tag;
         for (int i = 1; i < ANGLE_LAT + 2; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xm_ff <= sin_p * cos_t;
         ym_ff <= sin_p * sin_t;
         z1_ff <= cos_p;
         x2_ff <= TRIG_W'(round_shift(xm_ff, Q_BITS));
         y2_ff <= TRIG_W'(round_shift(ym_ff, Q_BITS));
         z2_ff <= z1_ff;
      end
   end

   always_comb begin
      norm_x_in = VAL_W'(clamp(clamp(round_shift(64'(x2_ff), Q_BITS - FRAC_BITS),
                                     NORM_LO, NORM_HI), OUT_LO, OUT_HI));
      norm_y_in = VAL_W'(clamp(clamp(round_shift(64'(y2_ff), Q_BITS - FRAC_BITS),
                                     NORM_LO, NORM_HI), OUT_LO, OUT_HI));
      norm_z_in = VAL_W'(clamp(clamp(round_shift(64'(z2_ff), Q_BITS - FRAC_BITS),
                                     NORM_LO, NORM_HI), OUT_LO, OUT_HI));
      pos_x_in = VAL_W'(clamp(round_shift(64'(x2_ff), Q_BITS + 1 - FRAC_BITS),
                              OUT_LO, OUT_HI));
      pos_y_in = VAL_W'(clamp(round_shift(64'(y2_ff), Q_BITS + 1 - FRAC_BITS),
                              OUT_LO, OUT_HI));
      pos_z_in = VAL_W'(clamp(round_shift(64'(z2_ff), Q_BITS + 1 - FRAC_BITS),
                              OUT_LO, OUT_HI));
      if (tag_ff[ANGLE_LAT+1].index_error) begin
         norm_x_in = '0;
         norm_y_in = '0;
         norm_z_in = '0;
         pos_x_in = '0;
         pos_y_in = '0;
         pos_z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[ANGLE_LAT+1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tag_ff <= tag_ff[ANGLE_LAT+1];
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         norm_x_ff <= norm_x_in;
         norm_y_ff <= norm_y_in;
         norm_z_ff <= norm_z_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pos_x = pos_x_ff;
   assign rsp_chan.pos_y = pos_y_ff;
   assign rsp_chan.pos_z = pos_z_ff;
   assign rsp_chan.norm_x = norm_x_ff;
   assign rsp_chan.norm_y = norm_y_ff;
   assign rsp_chan.norm_z = norm_z_ff;
   assign rsp_chan.corner = rsp_tag_ff.corner;
   assign rsp_chan.last_vertex = rsp_tag_ff.last_vertex;
   assign rsp_chan.index_error = rsp_tag_ff.index_error;

endmodule

/* verif/tb_sphere_tile_vertex_generator.sv */
// testbench of the sphere tile vertex generator: directed and random tile requests,
// register settings, vertex-by-vertex comparison against an in-bench Q30 trig predictor
// depends on stvg_pkg, the three channel interfaces and sphere_tile_vertex_generator
module tb_sphere_tile_vertex_generator;
   import stvg_pkg::*;

   typedef struct {
      logic signed [VAL_W-1:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z;
      corner_type corner;
      logic last_vertex;
      logic index_error;
   } vertex_type;

   localparam longint QONE = 64'd1 << 30;
   localparam longint HP   = 64'h6487ED51;
   localparam int     FB   = DEF_FRAC_BITS;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stvg_req_if req_chan ();
   stvg_rsp_if rsp_chan ();
   stvg_csr_if csr_chan ();

   sphere_tile_vertex_generator dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink));

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   vertex_type expected_vertices[$];
   int mismatch_count = 0;
   int vertex_count = 0;
   int tile_count = 0;
   int error_tiles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic [CNT_W-1:0] stack_cnt_reg = STACK_COUNT_RST;
   logic [CNT_W-1:0] half_cnt_reg  = HALF_SLICE_COUNT_RST;

   function automatic longint series_eval(longint a2, bit is_sin);
      longint t, sub;
      int d;
      t = QONE;
      for (int i = HORNER_TERMS - 1; i >= 0; i--) begin
         d = is_sin ? SIN_DIV[i] : COS_DIV[i];
         sub = ((a2 * t) >>> 30) / d;
         if (sub > QONE) sub = QONE;
         t = QONE - sub;
      end
      return t;
   endfunction

   // sine and cosine in Q30 of num/den of a full turn
   task automatic turn_sin_cos(input longint num, input longint den,
                               output longint sn, output longint cs);
      longint four, q, r, a, a2, s, c;
      four = num * 4;
      q = (four / den) & 3;
      r = four % den;
      a = (r * HP) / den;
      a2 = (a * a) >>> 30;
      s = (a * series_eval(a2, 1'b1)) >>> 30;
      c = series_eval(a2, 1'b0);
      if (s > QONE) s = QONE;
      case (q)
         0: begin sn = s;  cs = c;  end
         1: begin sn = c;  cs = -s; end
         2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
   endtask

   // multiplications up to 2^60 fit in a longint
   function automatic longint round_away(longint v, int sh);
      longint m;
      if (sh == 0) return v;
      m = v < 0 ? -v : v;
      m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic scale_unit(input longint u, output logic signed [VAL_W-1:0] p,
                             output logic signed [VAL_W-1:0] n);
      longint nn, pp;
      nn = clip(round_away(u, 30 - FB), -(64'sd1 <<< FB), (64'sd1 <<< FB) - 1);
      nn = clip(nn, -32768, 32767);
      pp = clip(round_away(u, 31 - FB), -32768, 32767);
      p = pp[VAL_W-1:0];
      n = nn[VAL_W-1:0];
   endtask

   task automatic predict_tile(input logic [SLICE_W-1:0] slice, input logic [STACK_W-1:0] stack);
      longint p, h, st, ct, sp, cp;
      bit err;
      vertex_type v;
      p = stack_cnt_reg < DEF_MAX_STACKS ? stack_cnt_reg : DEF_MAX_STACKS;
      h = half_cnt_reg < DEF_MAX_HALF_SLICES ? half_cnt_reg : DEF_MAX_HALF_SLICES;
      err = (p == 0) || (h == 0) || (stack >= p) || (slice >= 2 * h);
      if (err) error_tiles++;
      for (int k = 0; k < VTX_PER_TILE; k++) begin
         v.corner = CORNER_SEQ[k];
         v.last_vertex = (k == VTX_PER_TILE - 1);
         v.index_error = err;
         {v.pos_x, v.pos_y, v.pos_z, v.norm_x, v.norm_y, v.norm_z} = '0;
         if (!err) begin
            turn_sin_cos(slice + v.corner[0], 2 * h, st, ct);
            turn_sin_cos(stack + v.corner[1], 2 * p, sp, cp);
            scale_unit(round_away(sp * ct, 30), v.pos_x, v.norm_x);
            scale_unit(round_away(sp * st, 30), v.pos_y, v.norm_y);
            scale_unit(cp, v.pos_z, v.norm_z);
         end
         expected_vertices.insert(expected_vertices.size(), v);
      end
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      vertex_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         vertex_count++;
         if (expected_vertices.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected vertex: corner %0d pos %0d %0d %0d", rsp_chan.corner,
                        rsp_chan.pos_x, rsp_chan.pos_y, rsp_chan.pos_z);
         end else begin
            e = expected_vertices.pop_front();
            if (rsp_chan.pos_x !== e.pos_x || rsp_chan.pos_y !== e.pos_y ||
                rsp_chan.pos_z !== e.pos_z || rsp_chan.norm_x !== e.norm_x ||
                rsp_chan.norm_y !== e.norm_y || rsp_chan.norm_z !== e.norm_z ||
                rsp_chan.corner !== e.corner || rsp_chan.last_vertex !== e.last_vertex ||
                rsp_chan.index_error !== e.index_error) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("vertex mismatch at %0t", $time);
                  $display("  exp pos %0d %0d %0d norm %0d %0d %0d c%0d l%0d e%0d",
                           e.pos_x, e.pos_y, e.pos_z, e.norm_x, e.norm_y, e.norm_z,
                           e.corner, e.last_vertex, e.index_error);
                  $display("  got pos %0d %0d %0d norm %0d %0d %0d c%0d l%0d e%0d",
                           rsp_chan.pos_x, rsp_chan.pos_y, rsp_chan.pos_z, rsp_chan.norm_x,
                           rsp_chan.norm_y, rsp_chan.norm_z, rsp_chan.corner,
                           rsp_chan.last_vertex, rsp_chan.index_error);
               end
            end
         end
      end
   end

   // valid stays high across back-to-back items and drops only while idling
   task automatic send_tile(input logic [SLICE_W-1:0] slice, input logic [STACK_W-1:0] stack);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.slice_index <= slice;
      req_chan.stack_index <= stack;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_tile(slice, stack);
      tile_count++;
   endtask

   task automatic drain_vertices();
      req_chan.valid <= 1'b0;
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.wdata <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_STACK_COUNT) stack_cnt_reg = val;
      else if (idx == CSR_HALF_SLICE_COUNT) half_cnt_reg = val;
   endtask

   task automatic set_counts(input logic [CNT_W-1:0] stacks, input logic [CNT_W-1:0] halves);
      drain_vertices();
      write_reg(CSR_STACK_COUNT, stacks);
      write_reg(CSR_HALF_SLICE_COUNT, halves);
   endtask

   task automatic test_reset_defaults();
      send_tile(0, 0);
      send_tile(5, 0);
      send_tile(6, 0);
      send_tile(0, 1);
   endtask

   task automatic test_directed_extremes();
      set_counts(8'd255, 8'd255);
      send_tile(0, 0);
      send_tile(509, 254);
      send_tile(510, 0);
      send_tile(511, 255);
      send_tile(9'h155, 8'hAA);
      send_tile(9'h0AA, 8'h55);
      set_counts(8'd4, 8'd2);
      for (int s = 0; s < 4; s++) send_tile(SLICE_W'(s), STACK_W'(s));
      // zero counts make every tile an error, unknown register index is ignored
      set_counts(8'd0, 8'd5);
      send_tile(1, 0);
      set_counts(8'd7, 8'd0);
      send_tile(0, 0);
      drain_vertices();
      write_reg(8'd2, 8'd9);
      write_reg(8'hFF, 8'd1);
      set_counts(8'd1, 8'd1);
      send_tile(0, 0);
      send_tile(1, 0);
      send_tile(2, 0);
   endtask

   task automatic test_random_tiles(input int n);
      int p, h;
      for (int i = 0; i < n; i++) begin
         if (i % 50 == 0) begin
            case ($urandom_range(3))
               0: set_counts(CNT_W'($urandom_range(1, 255)), CNT_W'($urandom_range(1, 255)));
               1: set_counts(CNT_W'($urandom_range(1, 8)), CNT_W'($urandom_range(1, 8)));
               2: set_counts(8'd255, CNT_W'($urandom_range(1, 255)));
               default: set_counts(CNT_W'($urandom_range(1, 40)), 8'd255);
            endcase
         end
         if (i == n / 2) drain_vertices();
         p = stack_cnt_reg;
         h = half_cnt_reg;
         if ($urandom_range(9) < 8)
            send_tile(SLICE_W'($urandom_range(0, 2 * h - 1)),
                      STACK_W'($urandom_range(0, p - 1)));
         else
            send_tile(SLICE_W'($urandom_range(0, 511)), STACK_W'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.slice_index = '0;
      req_chan.stack_index = '0;
      csr_chan.valid = 1'b0;
      csr_chan.reg_index = '0;
      csr_chan.wdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 17;
      recv_idle_pct = 55;
      test_reset_defaults();
      test_directed_extremes();
      test_random_tiles(150);
      send_idle_pct = 55;
      recv_idle_pct = 17;
      test_random_tiles(150);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_tiles(150);
      drain_vertices();
      $display("covered %0d tiles (%0d out of range), %0d vertices checked",
               tile_count, error_tiles, vertex_count);
      if (mismatch_count == 0 && expected_vertices.size() == 0)
         $display("[sphere_tile_vertex_generator] OK");
      else
         $display("[sphere_tile_vertex_generator] ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("[sphere_tile_vertex_generator] ERROR");
      $finish;
   end
endmodule
